### design/bpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpr_pkg;

  // Packet section of the receiver
  typedef enum logic [2:0] {
    SEC_IDLE,
    SEC_PREAMBLE,
    SEC_HEADER,
    SEC_MESSAGE,
    SEC_CHECKSUM
  } sec_t;

  // Configuration register indexes
  typedef enum logic [7:0] {
    CFG_ZERO_LOW      = 8'd0,
    CFG_ZERO_HIGH     = 8'd1,
    CFG_ONE_LOW       = 8'd2,
    CFG_ONE_HIGH      = 8'd3,
    CFG_MIN_PREAMBLE  = 8'd4
  } cfg_reg_t;

  // Result kinds
  localparam logic [1:0] KIND_HEADER   = 2'd0;
  localparam logic [1:0] KIND_MESSAGE  = 2'd1;
  localparam logic [1:0] KIND_CHECKSUM = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_START        = 3'd1;
  localparam logic [2:0] ST_PARITY       = 3'd2;
  localparam logic [2:0] ST_STOP         = 3'd3;
  localparam logic [2:0] ST_SHORT_PREAMB = 3'd4;
  localparam logic [2:0] ST_TIMING       = 3'd5;
  localparam logic [2:0] ST_CHK_MISMATCH = 3'd6;
  localparam logic [2:0] ST_BAD_HEADER   = 3'd7;

  localparam int unsigned FIELD_STAMP_W = 16;

  typedef struct packed {
    logic [15:0] edge_stamp;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic [1:0] byte_kind;
    logic [4:0] message_length;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  reg_index;
    logic [15:0] wr_data;
  } cfg_item_t;

  // Message length from header byte; zero means unknown header
  function automatic logic [4:0] header_length(input logic [7:0] h);
    logic [4:0] len;
    case (h) inside
      [8'h01:8'h1F]: len = 5'd1;
      [8'h20:8'h2F]: len = 5'd2;
      [8'h30:8'h3F]: len = 5'd3;
      8'h48:         len = 5'd4;
      [8'h51:8'h5F]: len = 5'd5;
      8'h68:         len = 5'd6;
      [8'h71:8'h7F]: len = 5'd7;
      [8'h81:8'h8F]: len = 5'd8;
      8'hA4:         len = 5'd12;
      8'hC4:         len = 5'd16;
      8'hE2:         len = 5'd20;
      default:       len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### design/bpr_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bpr_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/biphase_packet_receiver_unit.sv
// An accepted edge transaction goes through the input register, then is decoded
//   into the result register that drives out_chan.
// Throughput: one edge per cycle while no held result stalls the input register.
// A held result stalls the input register only, so one more edge is still taken.
// Reset (rst_n low, synchronous): section idle, all counters, stamp and
//   config registers back to their defaults; no result pending.
`timescale 1ns / 1ps
`default_nettype none

module biphase_packet_receiver_unit
  import bpr_pkg::*;
#(
  parameter int unsigned MAX_MESSAGE_BYTES = 20,
  parameter int unsigned STAMP_BITS        = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bpr_chan_if.sink    in_chan,
  bpr_chan_if.source  out_chan,
  bpr_chan_if.sink    cfg_chan
);

  // Stamps wrap at STAMP_BITS; the 16-bit field is zero-extended or cut to fit.
  // Interval compares run at the wider of the stamp and window widths.
  localparam int unsigned SW = STAMP_BITS;
  localparam int unsigned CW = (STAMP_BITS > FIELD_STAMP_W) ? STAMP_BITS : FIELD_STAMP_W;
  localparam logic [4:0]  LEN_CAP = 5'(MAX_MESSAGE_BYTES);

  // ---------------- configuration registers ----------------
  logic [15:0] zero_low_r, zero_high_r, one_low_r, one_high_r;
  logic [7:0]  min_pre_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_low_r  <= 16'd400;
      zero_high_r <= 16'd600;
      one_low_r   <= 16'd150;
      one_high_r  <= 16'd350;
      min_pre_r   <= 8'd4;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.data.reg_index)
        CFG_ZERO_LOW:     zero_low_r  <= cfg_chan.data.wr_data;
        CFG_ZERO_HIGH:    zero_high_r <= cfg_chan.data.wr_data;
        CFG_ONE_LOW:      one_low_r   <= cfg_chan.data.wr_data;
        CFG_ONE_HIGH:     one_high_r  <= cfg_chan.data.wr_data;
        CFG_MIN_PREAMBLE: min_pre_r   <= cfg_chan.data.wr_data[7:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---------------- handshake / stage control ----------------
  logic          s1_valid_r, s1_valid_nxt;
  logic [SW-1:0] s1_stamp_r;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r;
  logic          stall;   // result register full and not being taken
  logic          proc;    // input register item is decoded this cycle
  logic          in_acc;

  assign stall          = out_valid_r && !out_chan.ready;
  assign proc           = s1_valid_r && !stall;
  assign in_chan.ready  = !s1_valid_r || !stall;
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // ---------------- decode state ----------------
  logic [SW-1:0] prev_r, prev_nxt;
  logic          skip_r, skip_nxt;
  sec_t          sec_r, sec_nxt;
  logic [7:0]    halves_r, halves_nxt;
  logic [3:0]    bit_idx_r, bit_idx_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic          par_r, par_nxt;
  logic [4:0]    rcvd_r, rcvd_nxt;
  logic [4:0]    exp_len_r, exp_len_nxt;
  logic [7:0]    xor_r, xor_nxt;

  // decode scratch
  logic [SW-1:0] diff;
  logic [CW-1:0] diff_w;
  logic          is_zero, is_one, bit_val;
  logic          do_fail, do_idle;
  logic [2:0]    fail_st;
  logic [4:0]    hdr_len;
  logic [7:0]    byte_done;
  logic          res_load;
  out_item_t     res;

  assign diff    = s1_stamp_r - prev_r;
  assign diff_w  = CW'(diff);
  assign is_zero = (diff_w >= CW'(zero_low_r)) && (diff_w < CW'(zero_high_r));
  assign is_one  = (diff_w > CW'(one_low_r)) && (diff_w < CW'(one_high_r));
  assign bit_val = !is_zero;   // only meaningful when is_zero or is_one
  assign hdr_len = header_length(shift_r);

  always_comb begin
    prev_nxt    = prev_r;
    skip_nxt    = skip_r;
    sec_nxt     = sec_r;
    halves_nxt  = halves_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    par_nxt     = par_r;
    rcvd_nxt    = rcvd_r;
    exp_len_nxt = exp_len_r;
    xor_nxt     = xor_r;
    do_fail     = 1'b0;
    do_idle     = 1'b0;
    fail_st     = ST_OK;
    res_load    = 1'b0;
    res         = '0;
    byte_done   = shift_r;

    if (proc) begin
      prev_nxt = s1_stamp_r;
      if (skip_r) begin
        // second half of a data one: interval is not checked
        skip_nxt = 1'b0;
      end else if (!(is_zero || is_one)) begin
        if (sec_r == SEC_IDLE || sec_r == SEC_PREAMBLE) begin
          skip_nxt = 1'b0;
          do_idle  = 1'b1;
        end else begin
          do_fail = 1'b1;
          fail_st = ST_TIMING;
        end
      end else if (sec_r == SEC_IDLE || sec_r == SEC_PREAMBLE) begin
        if (bit_val) begin
          if (halves_r != 8'hFF) halves_nxt = halves_r + 8'd1;
          sec_nxt = SEC_PREAMBLE;
        end else if (halves_r > min_pre_r) begin
          // header start bit
          sec_nxt     = SEC_HEADER;
          bit_idx_nxt = 4'd1;
          shift_nxt   = '0;
          par_nxt     = 1'b0;
        end else begin
          do_fail = 1'b1;
          fail_st = ST_SHORT_PREAMB;
        end
      end else begin
        if (bit_val) skip_nxt = 1'b1;
        if (bit_idx_r == 4'd0) begin
          if (bit_val) begin
            do_fail = 1'b1;
            fail_st = ST_START;
          end else begin
            shift_nxt   = '0;
            par_nxt     = 1'b0;
            bit_idx_nxt = 4'd1;
          end
        end else if (bit_idx_r <= 4'd8) begin
          shift_nxt   = {bit_val, shift_r[7:1]};
          par_nxt     = par_r ^ bit_val;
          bit_idx_nxt = bit_idx_r + 4'd1;
        end else if (bit_idx_r == 4'd9) begin
          if (par_r == bit_val) begin
            do_fail = 1'b1;
            fail_st = ST_PARITY;
          end else begin
            bit_idx_nxt = 4'd10;
          end
        end else if (!bit_val) begin
          do_fail = 1'b1;
          fail_st = ST_STOP;
        end else begin
          // stop bit good: a byte is complete
          bit_idx_nxt = 4'd0;
          unique case (sec_r)
            SEC_HEADER: begin
              if (hdr_len == 5'd0) begin
                do_fail = 1'b1;
                fail_st = ST_BAD_HEADER;
              end else begin
                exp_len_nxt = (hdr_len > LEN_CAP) ? LEN_CAP : hdr_len;
                xor_nxt     = byte_done;
                rcvd_nxt    = '0;
                sec_nxt     = SEC_MESSAGE;
                res_load    = 1'b1;
                res         = '{byte_value: byte_done, byte_kind: KIND_HEADER,
                                message_length: exp_len_nxt, status: ST_OK, last: 1'b0};
              end
            end
            SEC_MESSAGE: begin
              xor_nxt  = xor_r ^ byte_done;
              rcvd_nxt = rcvd_r + 5'd1;
              if (rcvd_nxt >= exp_len_r) sec_nxt = SEC_CHECKSUM;
              res_load = 1'b1;
              res      = '{byte_value: byte_done, byte_kind: KIND_MESSAGE,
                           message_length: exp_len_r, status: ST_OK, last: 1'b0};
            end
            default: begin
              // checksum; the stop bit's skip is kept
              res_load = 1'b1;
              res      = '{byte_value: byte_done, byte_kind: KIND_CHECKSUM,
                           message_length: exp_len_r,
                           status: (xor_r == byte_done) ? ST_OK : ST_CHK_MISMATCH,
                           last: 1'b1};
              do_idle  = 1'b1;
            end
          endcase
        end
      end

      if (do_fail) begin
        res_load = 1'b1;
        res      = '{byte_value: 8'd0, byte_kind: KIND_ERROR,
                     message_length: exp_len_r, status: fail_st, last: 1'b1};
        skip_nxt = 1'b0;
        do_idle  = 1'b1;
      end
      if (do_idle) begin
        sec_nxt     = SEC_IDLE;
        halves_nxt  = '0;
        bit_idx_nxt = '0;
        shift_nxt   = '0;
        par_nxt     = 1'b0;
        rcvd_nxt    = '0;
        exp_len_nxt = '0;
        xor_nxt     = '0;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc)    s1_valid_nxt = 1'b1;
    else if (proc) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (res_load)            out_valid_nxt = 1'b1;
    else if (out_chan.ready) out_valid_nxt = 1'b0;
  end

  // control and decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      skip_r      <= 1'b0;
      sec_r       <= SEC_IDLE;
      halves_r    <= '0;
      bit_idx_r   <= '0;
      shift_r     <= '0;
      par_r       <= 1'b0;
      rcvd_r      <= '0;
      exp_len_r   <= '0;
      xor_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
      skip_r      <= skip_nxt;
      sec_r       <= sec_nxt;
      halves_r    <= halves_nxt;
      bit_idx_r   <= bit_idx_nxt;
      shift_r     <= shift_nxt;
      par_r       <= par_nxt;
      rcvd_r      <= rcvd_nxt;
      exp_len_r   <= exp_len_nxt;
      xor_r       <= xor_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc)   s1_stamp_r <= SW'(in_chan.data.edge_stamp);
    if (res_load) out_data_r <= res;
  end

  // ---------------- assertions ----------------
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last) |->
      (out_data_r.byte_kind == KIND_CHECKSUM || out_data_r.byte_kind == KIND_ERROR))
    else $error("last flag on a header or message byte");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.byte_kind == KIND_ERROR) |->
      (out_data_r.byte_value == 8'd0 && out_data_r.status != ST_OK))
    else $error("error result carries data or ok status");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && res.last) |=> (sec_r == SEC_IDLE))
    else $error("packet end did not return to idle");

  a_bit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    bit_idx_r <= 4'd10)
    else $error("frame bit index out of range");

  a_skip_sec: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> (sec_r != SEC_PREAMBLE))
    else $error("pending half-bit skip while in preamble");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> (out_valid_r && $stable(out_data_r)))
    else $error("held result lost or overwritten");

endmodule

`default_nettype wire

### tb/sv/tb_biphase_packet_receiver_unit.sv
`timescale 1ns / 1ps

// Edge transactions go in, decoded bytes come out. A local decoder tracks the
// interval windows, preamble count and frame position for each accepted edge
// and queues the byte it should produce; every byte transaction is checked
// against the front of that queue.
module tb_biphase_packet_receiver_unit;
  import bpr_pkg::*;

  localparam int unsigned MAX_MSG     = 20;
  localparam int unsigned OUT_HOLD    = 400;    // long output stall, in cycles
  localparam int unsigned LAT_TAIL    = 8;      // pipeline is 2 deep, keep margin
  localparam int unsigned CYCLE_LIMIT = 500000;

  // Ways a generated packet can be damaged
  typedef enum int unsigned {
    FLAW_NONE,
    FLAW_PARITY,
    FLAW_STOP,
    FLAW_START,
    FLAW_CHECKSUM,
    FLAW_TIMING,
    FLAW_SHORT
  } flaw_t;

  // One row of the directed edge table
  typedef struct {
    logic [15:0] stamp;
    bit          typed;
    bit          has;
    out_item_t   want;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n;

  bpr_chan_if #(.payload_t(in_item_t))  in_chan ();
  bpr_chan_if #(.payload_t(out_item_t)) out_chan ();
  bpr_chan_if #(.payload_t(cfg_item_t)) cfg_chan ();

  biphase_packet_receiver_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Local decoder: window registers and packet state
  // ---------------------------------------------------------------------------
  logic [15:0] zlo, zhi, olo, ohi;
  logic [7:0]  pre_min;

  logic [15:0] last_edge;
  bit          skip_half;    // second half of a data one is not timed
  sec_t        section;
  logic [7:0]  halves;
  logic [3:0]  bit_pos;      // 0 start, 1..8 data, 9 parity, 10 stop
  logic [7:0]  data_sr;
  bit          par_acc;
  logic [4:0]  msg_count;
  logic [4:0]  msg_len;
  logic [7:0]  xor_acc;

  out_item_t   byte_q [$];   // bytes still owed by the block
  probe_row_t  probes [$];
  logic [15:0] plan_q [$];   // intervals of the packet being built

  logic [15:0] stamp_now;
  bit          src_calm, sink_calm, stall_req;
  int unsigned mismatches, edges_sent, bytes_checked, packets, settings;
  int unsigned cycle_count;

  function automatic logic [4:0] len_for_header(input logic [7:0] h);
    if (h == 8'h00) return 5'd0;
    if (h < 8'h20) return 5'd1;
    if (h < 8'h30) return 5'd2;
    if (h < 8'h40) return 5'd3;
    if (h == 8'h48) return 5'd4;
    if (h > 8'h50 && h < 8'h60) return 5'd5;
    if (h == 8'h68) return 5'd6;
    if (h > 8'h70 && h < 8'h80) return 5'd7;
    if (h > 8'h80 && h < 8'h90) return 5'd8;
    if (h == 8'hA4) return 5'd12;
    if (h == 8'hC4) return 5'd16;
    if (h == 8'hE2) return 5'd20;
    return 5'd0;
  endfunction

  function automatic bit in_zero(input logic [15:0] d);
    return d >= zlo && d < zhi;
  endfunction

  function automatic bit in_one(input logic [15:0] d);
    return d > olo && d < ohi;
  endfunction

  function automatic void clear_packet();
    section   = SEC_IDLE;
    halves    = 8'd0;
    bit_pos   = 4'd0;
    data_sr   = 8'd0;
    par_acc   = 1'b0;
    msg_count = 5'd0;
    msg_len   = 5'd0;
    xor_acc   = 8'd0;
  endfunction

  // Error byte: reports the length in effect, then drops back to idle
  function automatic bit abort_packet(input logic [2:0] why, output out_item_t res);
    res = '{byte_value: 8'd0, byte_kind: KIND_ERROR, message_length: msg_len,
            status: why, last: 1'b1};
    skip_half = 1'b0;
    clear_packet();
    return 1'b1;
  endfunction

  // One accepted edge; returns 1 when a byte transaction is owed
  function automatic bit decode_edge(input logic [15:0] stamp, output out_item_t res);
    logic [15:0] span;
    bit          b;
    logic [4:0]  hl;
    span = stamp - last_edge;   // 16-bit wrap is the modulo we want
    last_edge = stamp;
    res = '0;
    if (skip_half) begin
      skip_half = 1'b0;
      return 1'b0;
    end
    if (in_zero(span)) begin
      b = 1'b0;
    end else if (in_one(span)) begin
      b = 1'b1;
    end else begin
      if (section >= SEC_HEADER) return abort_packet(ST_TIMING, res);
      skip_half = 1'b0;
      clear_packet();
      return 1'b0;
    end

    // idle and preamble: count halves until a start bit
    if (section < SEC_HEADER) begin
      if (b) begin
        if (halves != 8'hFF) halves = halves + 8'd1;
        section = SEC_PREAMBLE;
        return 1'b0;
      end
      if (halves > pre_min) begin
        section = SEC_HEADER;
        bit_pos = 4'd1;
        data_sr = 8'd0;
        par_acc = 1'b0;
        return 1'b0;
      end
      return abort_packet(ST_SHORT_PREAMB, res);
    end

    if (b) skip_half = 1'b1;
    if (bit_pos == 4'd0) begin
      if (b) return abort_packet(ST_START, res);
      data_sr = 8'd0;
      par_acc = 1'b0;
      bit_pos = 4'd1;
      return 1'b0;
    end
    if (bit_pos <= 4'd8) begin
      data_sr = {b, data_sr[7:1]};
      par_acc ^= b;
      bit_pos = bit_pos + 4'd1;
      return 1'b0;
    end
    if (bit_pos == 4'd9) begin
      if (par_acc == b) return abort_packet(ST_PARITY, res);
      bit_pos = 4'd10;
      return 1'b0;
    end
    if (!b) return abort_packet(ST_STOP, res);
    bit_pos = 4'd0;

    case (section)
      SEC_HEADER: begin
        hl = len_for_header(data_sr);
        if (hl == 5'd0) return abort_packet(ST_BAD_HEADER, res);
        msg_len   = (hl > MAX_MSG) ? 5'(MAX_MSG) : hl;
        xor_acc   = data_sr;
        msg_count = 5'd0;
        section   = SEC_MESSAGE;
        res = '{byte_value: data_sr, byte_kind: KIND_HEADER, message_length: msg_len,
                status: ST_OK, last: 1'b0};
      end
      SEC_MESSAGE: begin
        xor_acc   ^= data_sr;
        msg_count = msg_count + 5'd1;
        if (msg_count >= msg_len) section = SEC_CHECKSUM;
        res = '{byte_value: data_sr, byte_kind: KIND_MESSAGE, message_length: msg_len,
                status: ST_OK, last: 1'b0};
      end
      default: begin
        // skip_half stays set: the stop bit's second half still comes
        res = '{byte_value: data_sr, byte_kind: KIND_CHECKSUM, message_length: msg_len,
                status: (xor_acc == data_sr) ? ST_OK : ST_CHK_MISMATCH, last: 1'b1};
        clear_packet();
      end
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Interval generation for the windows currently loaded
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] zero_span();
    return 16'($urandom_range(int'(zlo), int'(zhi) - 1));
  endfunction

  function automatic logic [15:0] one_span();
    logic [15:0] d;
    d = olo;
    for (int k = 0; k < 32; k++) begin
      d = 16'($urandom_range(int'(olo) + 1, int'(ohi) - 1));
      if (in_one(d) && !in_zero(d)) return d;
    end
    return d;
  endfunction

  // interval that falls in neither window
  function automatic logic [15:0] junk_span();
    logic [15:0] d;
    for (int k = 0; k < 40; k++) begin
      if (k[0]) begin
        case ($urandom_range(0, 3))
          0: d = zhi;
          1: d = ohi;
          2: d = olo;
          default: d = zlo - 16'd1;
        endcase
      end else begin
        d = 16'($urandom);
      end
      if (!in_zero(d) && !in_one(d)) return d;
    end
    return 16'($urandom);
  endfunction

  // a one adds a timed interval and then an untimed one, which may be anything
  function automatic void add_bit(input bit b);
    if (!b) begin
      plan_q.push_back(zero_span());
    end else begin
      plan_q.push_back(one_span());
      plan_q.push_back(($urandom_range(0, 3) == 0) ? 16'($urandom) : one_span());
    end
  endfunction

  function automatic void add_frame(input logic [7:0] v, input flaw_t flaw, input bit hit);
    add_bit(hit && flaw == FLAW_START);
    for (int i = 0; i < 8; i++) add_bit(v[i]);
    add_bit(~^v ^ (hit && flaw == FLAW_PARITY));
    add_bit(!(hit && flaw == FLAW_STOP));
  endfunction

  // mostly short messages; long ones now and then
  function automatic logic [7:0] pick_header();
    case ($urandom_range(0, 15))
      0, 1, 2, 3: return 8'($urandom_range(8'h01, 8'h1F));
      4, 5, 6:    return 8'($urandom_range(8'h20, 8'h2F));
      7, 8:       return 8'($urandom_range(8'h30, 8'h3F));
      9:          return 8'h48;
      10:         return 8'($urandom_range(8'h51, 8'h5F));
      11:         return 8'h68;
      12:         return 8'($urandom_range(8'h71, 8'h7F));
      13:         return 8'($urandom_range(8'h81, 8'h8F));
      14:         return 8'hA4;
      default:    return ($urandom_range(0, 1) != 0) ? 8'hC4 : 8'hE2;
    endcase
  endfunction

  function automatic out_item_t err_byte(input logic [2:0] st);
    return '{byte_value: 8'd0, byte_kind: KIND_ERROR, message_length: 5'd0,
             status: st, last: 1'b1};
  endfunction

  function automatic void probe(input logic [15:0] s, input bit typed, input bit has,
                                input out_item_t want);
    probe_row_t r;
    r.stamp = s;
    r.typed = typed;
    r.has   = has;
    r.want  = want;
    probes.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge
  // ---------------------------------------------------------------------------

  // Offer one edge; on acceptance run the local decoder. Typed rows carry
  // their own expectation instead of the decoder's.
  task automatic push_edge(input logic [15:0] stamp, input bit typed = 1'b0,
                           input bit t_has = 1'b0, input out_item_t t_res = '0);
    int unsigned gap;
    bit          got;
    out_item_t   res;
    gap = src_calm ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data.edge_stamp <= stamp;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    got = decode_edge(stamp, res);
    if (typed) begin
      got = t_has;
      res = t_res;
    end
    if (got) byte_q.push_back(res);
    stamp_now = stamp;
    edges_sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= cfg_item_t'{reg_index: idx, wr_data: val};
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    case (idx)
      CFG_ZERO_LOW:     zlo = val;
      CFG_ZERO_HIGH:    zhi = val;
      CFG_ONE_LOW:      olo = val;
      CFG_ONE_HIGH:     ohi = val;
      CFG_MIN_PREAMBLE: pre_min = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // upper byte of the preamble count write is noise the block must drop
  task automatic load_windows(input logic [15:0] z_lo, input logic [15:0] z_hi,
                              input logic [15:0] o_lo, input logic [15:0] o_hi,
                              input logic [7:0] p_min);
    write_reg(CFG_ZERO_LOW, z_lo);
    write_reg(CFG_ZERO_HIGH, z_hi);
    write_reg(CFG_ONE_LOW, o_lo);
    write_reg(CFG_ONE_HIGH, o_hi);
    write_reg(CFG_MIN_PREAMBLE, {8'($urandom), p_min});
    settings++;
  endtask

  // Two disjoint windows split around s, in either order
  task automatic load_random_windows();
    int unsigned s, a, b, c, d;
    s = $urandom_range(200, 65000);
    a = $urandom_range(0, s / 2);
    b = $urandom_range(a + 2, s);
    c = $urandom_range(s, (s + 65535) / 2);
    d = $urandom_range(c + 2, 65535);
    if ($urandom_range(0, 1) != 0)
      load_windows(16'(c), 16'(d), 16'(a), 16'(b), 8'($urandom_range(0, 6)));
    else
      load_windows(16'(a), 16'(b), 16'(c), 16'(d), 8'($urandom_range(0, 6)));
  endtask

  // Hold input idle until every owed byte is out, then let the pipe drain
  task automatic settle();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
    repeat (LAT_TAIL) @(posedge clk);
  endtask

  // Preamble, header, message, checksum; about half carry one flaw
  task automatic send_packet(input bit fixed = 1'b0, input logic [7:0] fixed_hdr = 8'h00);
    logic [7:0]  hdr, csum;
    logic [7:0]  body [$];
    logic [4:0]  hl;
    flaw_t       flaw;
    int unsigned n_body, n_halves, bad_frame;
    if (fixed) flaw = FLAW_NONE;
    else if ($urandom_range(0, 1) != 0) flaw = FLAW_NONE;
    else flaw = flaw_t'($urandom_range(1, 6));
    if (fixed) hdr = fixed_hdr;
    else if ($urandom_range(0, 9) == 0) hdr = 8'($urandom);   // often unknown
    else hdr = pick_header();
    hl = len_for_header(hdr);
    n_body = (hl == 5'd0) ? $urandom_range(0, 2) : int'(hl);
    csum = hdr;
    for (int i = 0; i < int'(n_body); i++) begin
      body.push_back(8'($urandom));
      csum ^= body[i];
    end
    if (flaw == FLAW_CHECKSUM) csum ^= 8'($urandom_range(1, 255));
    if (flaw == FLAW_SHORT) n_halves = $urandom_range(0, int'(pre_min));
    else n_halves = int'(pre_min) + 1 + $urandom_range(0, 3);
    bad_frame = $urandom_range(0, n_body + 1);

    plan_q.delete();
    repeat (n_halves) plan_q.push_back(one_span());
    add_frame(hdr, flaw, bad_frame == 0);
    for (int i = 0; i < int'(n_body); i++) add_frame(body[i], flaw, bad_frame == i + 1);
    add_frame(csum, flaw, bad_frame == n_body + 1);
    if (flaw == FLAW_TIMING) plan_q.insert($urandom_range(0, plan_q.size()), junk_span());

    foreach (plan_q[i]) push_edge(stamp_now + plan_q[i]);
    packets++;
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned stop_at;
    stop_at = edges_sent + budget;
    while (edges_sent < stop_at) begin
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        // line noise: absolute junk and out-of-window gaps
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) != 0) push_edge(16'($urandom));
          else push_edge(stamp_now + junk_span());
        end
      end else begin
        send_packet();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: draws a wait per byte; a requested stall holds ready low
  // ---------------------------------------------------------------------------
  initial begin : byte_sink
    int unsigned hold;
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      hold = sink_calm ? 0 : $urandom_range(0, 16);
      if (stall_req) begin
        hold = OUT_HOLD;
        stall_req = 1'b0;
      end
      if (hold != 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatches++;
    $display("MISMATCH %s: got %0h want %0h (byte %0d)", what, got, want, bytes_checked);
  endtask

  // Byte transaction check, field by field against the oldest owed byte
  always @(posedge clk) begin
    out_item_t seen, want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen = out_chan.data;
      if (byte_q.size() == 0) begin
        note_mismatch("unexpected byte", seen, 0);
      end else begin
        want = byte_q.pop_front();
        if (seen.byte_value != want.byte_value)
          note_mismatch("byte_value", seen.byte_value, want.byte_value);
        if (seen.byte_kind != want.byte_kind)
          note_mismatch("byte_kind", seen.byte_kind, want.byte_kind);
        if (seen.message_length != want.message_length)
          note_mismatch("message_length", seen.message_length, want.message_length);
        if (seen.status != want.status)
          note_mismatch("status", seen.status, want.status);
        if (seen.last != want.last)
          note_mismatch("last", seen.last, want.last);
      end
      bytes_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes still owed", cycle_count, byte_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.data  = '0;
    cycle_count    = 0;
    mismatches     = 0;
    edges_sent     = 0;
    bytes_checked  = 0;
    packets        = 0;
    settings       = 1;
    src_calm       = 1'b0;
    sink_calm      = 1'b0;
    stall_req      = 1'b0;
    stamp_now      = 16'd0;
    // decoder state and windows as after reset
    zlo = 16'd400;
    zhi = 16'd600;
    olo = 16'd150;
    ohi = 16'd350;
    pre_min   = 8'd4;
    last_edge = 16'd0;
    skip_half = 1'b0;
    clear_packet();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed edges at reset windows (zero 400..599, one 151..349, > 4 halves)
    probe(16'd0,     1, 0, '0);                        // equal stamps: gap 0, silent
    probe(16'd500,   1, 1, err_byte(ST_SHORT_PREAMB)); // zero straight from idle
    probe(16'd65535, 1, 0, '0);                        // out of window while idle
    probe(16'd199,   0, 0, '0);                        // wraps to a 200 gap: half 1
    probe(16'd399,   0, 0, '0);
    probe(16'd599,   0, 0, '0);
    probe(16'd799,   0, 0, '0);
    probe(16'd999,   0, 0, '0);                        // five halves
    probe(16'd1499,  0, 0, '0);                        // header start
    for (int i = 0; i < 8; i++) probe(16'(1999 + 500 * i), 0, 0, '0);  // data all zero
    probe(16'd5999,  1, 1, err_byte(ST_PARITY));       // even parity bit
    probe(16'd6199,  0, 0, '0);
    probe(16'd6399,  0, 0, '0);
    probe(16'd6599,  0, 0, '0);
    probe(16'd6799,  0, 0, '0);
    probe(16'd6999,  0, 0, '0);
    probe(16'd7499,  0, 0, '0);                        // header start
    probe(16'd8499,  1, 1, err_byte(ST_TIMING));       // 1000 gap inside a frame
    foreach (probes[i]) push_edge(probes[i].stamp, probes[i].typed, probes[i].has,
                                  probes[i].want);
    settle();

    // Reset windows written back explicitly; a long packet is sent flat out
    // while the result side stalls, so the block backs up
    load_windows(16'd400, 16'd600, 16'd150, 16'd350, 8'd4);
    stall_req = 1'b1;
    src_calm  = 1'b1;
    send_packet(1'b1, 8'hA4);
    settle();

    // Tightest windows, one preamble half is enough
    load_windows(16'd0, 16'd3, 16'd2, 16'd6, 8'd0);
    run_phase(40);
    settle();

    // Windows reaching the top of the counter range
    load_windows(16'd60000, 16'd65535, 16'd0, 16'd65535, 8'd1);
    run_phase(40);
    settle();

    // Saturated preamble count can never exceed the maximum threshold
    load_windows(16'd65534, 16'd65535, 16'd65532, 16'd65534, 8'd255);
    run_phase(100);
    settle();

    repeat (3) begin
      load_random_windows();
      run_phase(10);
      settle();
    end

    $display("Covered %0d edge transactions, %0d packets, %0d window settings",
             edges_sent, packets, settings);
    $display("Checked %0d byte transactions, incl. a %0d-cycle output stall",
             bytes_checked, OUT_HOLD);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
design/bpr_pkg.sv
design/bpr_chan_if.sv
design/biphase_packet_receiver_unit.sv
tb/sv/tb_biphase_packet_receiver_unit.sv
